// ----- hdl/min_priority_queue_top_assert.svh -----
// ---------------------------------------------------------------------------
// min_priority_queue_top_assert.svh
// Assertion macros for the min priority queue. Empty bodies under SYNTH.
// ---------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held
`define MPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is held
`define MPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/mpq_pkg.sv -----
// ---------------------------------------------------------------------------
// mpq_pkg
// Types, codes and defaults shared by the min priority queue modules.
// ---------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;

    typedef logic signed [KEY_W-1:0] t_key;

    // Operation selector on the input stream
    typedef enum logic {
        KIND_INSERT  = 1'b0,
        KIND_EXTRACT = 1'b1
    } t_kind;

    // Result status on the output stream
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic ins;   // insert commits this cycle
        logic ext;   // extract commits this cycle
    } t_cell_ctl;

endpackage

// ----- hdl/mpq_cell.sv -----
// ---------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted key chain. On insert a cell whose key is greater
// than the new key takes its left neighbor's key, or the new key if it is
// the first such cell. On extract it takes its right neighbor's key.
// ---------------------------------------------------------------------------
module mpq_cell (
    input  logic               i_clk,
    input  mpq_pkg::t_cell_ctl i_ctl,
    input  logic               i_empty,     // slot is at or past the fill count
    input  mpq_pkg::t_key      i_new_key,
    input  mpq_pkg::t_key      i_left_key,
    input  logic               i_left_gt,
    input  mpq_pkg::t_key      i_right_key,
    output logic               o_gt,
    output mpq_pkg::t_key      o_key
);
    import mpq_pkg::*;

    t_key r_key;
    t_key n_key;

    // Empty slots act as plus infinity; equal keys stay ahead of the new one
    assign o_gt  = i_empty || (r_key > i_new_key);
    assign o_key = r_key;

    // Next key: shift right / drop in on insert, shift left on extract
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && o_gt) begin
            n_key = i_left_gt ? i_left_key : i_new_key;
        end else if (i_ctl.ext) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ----- hdl/min_priority_queue_top.sv -----
// ---------------------------------------------------------------------------
// min_priority_queue_top
// Bounded min priority queue built as a sorted chain of key cells.
// Results are registered: an accepted transaction's result is on the output register in the next cycle.
// Throughput: one item per cycle while the output stream is not stalled; every cell updates in parallel from its
// neighbors, and the smallest key always sits in the first cell.
// Reset: the fill count and output valid clear; the queue starts empty.
// ---------------------------------------------------------------------------
`include "min_priority_queue_top_assert.svh"

module min_priority_queue_top #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((mpq_pkg::KEY_W + CNT_W + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [mpq_pkg::KEY_W-1:0]    i_s_tdata,   // [31:0] key
    input  logic                         i_s_tuser,   // [0] kind
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_W-1:0]             o_m_tdata,   // min_key, occupancy, zero pad
    output logic [mpq_pkg::STATUS_W-1:0] o_m_tuser    // status
);
    import mpq_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);
    localparam int               PAD_W   = OUT_W - KEY_W - CNT_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_key             r_min_key;
    t_key             n_min_key;
    t_status          r_status;
    t_status          n_status;

    logic             w_acc;
    logic             w_full;
    logic             w_empty;
    t_cell_ctl        w_ctl;
    t_key             w_new_key;
    t_key             w_key [CAPACITY];
    logic             w_gt  [CAPACITY];

    // Output register frees when empty or being drained
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_MAX);
    assign w_empty    = (r_count == '0);
    assign w_new_key  = t_key'(i_s_tdata);

    // Commands and result for the accepted transaction
    always_comb begin
        w_ctl     = '0;
        n_count   = r_count;
        n_min_key = '0;
        n_status  = ST_INSERTED;
        unique case (t_kind'(i_s_tuser))
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + 1'b1;
                end
            end
            KIND_EXTRACT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.ext = w_acc;
                    n_status  = ST_EXTRACTED;
                    n_min_key = w_key[0];
                    n_count   = r_count - 1'b1;
                end
            end
            default: n_status = ST_INSERTED;
        endcase
    end

    // Chain of sorted cells, smallest key in cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_left_key;
        logic w_left_gt;
        t_key w_right_key;
        logic w_slot_empty;

        if (g == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_mid
            assign w_left_key = w_key[g-1];
            assign w_left_gt  = w_gt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = '0;
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
        end
        assign w_slot_empty = (r_count <= CNT_W'(g));

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_empty     (w_slot_empty),
            .i_new_key   (w_new_key),
            .i_left_key  (w_left_key),
            .i_left_gt   (w_left_gt),
            .i_right_key (w_right_key),
            .o_gt        (w_gt[g]),
            .o_key       (w_key[g])
        );
    end

    // Fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_min_key <= n_min_key;
            r_status  <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    if (PAD_W > 0) begin : g_pad
        assign o_m_tdata = {{PAD_W{1'b0}}, r_count, r_min_key};
    end else begin : g_nopad
        assign o_m_tdata = {r_count, r_min_key};
    end

    // Checks
    `MPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)
    `MPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctl.ins, r_count == $past(r_count) + 1'b1)
    `MPQ_ASSERT_NOW(a_head_sorted, i_clk, i_rst_n, r_count >= CNT_W'(2), w_key[0] <= w_key[1])
    `MPQ_ASSERT_NEXT(a_extract_status, i_clk, i_rst_n, w_ctl.ext, o_m_tuser == ST_EXTRACTED)

endmodule
